[rtl/core/mmcfsm_pkg.sv]
package mmcfsm_pkg;

  localparam int unsigned OpcodeW = 6;
  localparam int unsigned FunctW  = 6;

  localparam logic [OpcodeW-1:0] OP_SPECIAL = 6'h00;
  localparam logic [OpcodeW-1:0] OP_J       = 6'h02;
  localparam logic [OpcodeW-1:0] OP_JAL     = 6'h03;
  localparam logic [OpcodeW-1:0] OP_BEQ     = 6'h04;
  localparam logic [OpcodeW-1:0] OP_BNE     = 6'h05;
  localparam logic [OpcodeW-1:0] OP_ADD_IMM = 6'h09;
  localparam logic [OpcodeW-1:0] OP_SLTI    = 6'h0A;
  localparam logic [OpcodeW-1:0] OP_LTU_IMM = 6'h0B;
  localparam logic [OpcodeW-1:0] OP_ANDI    = 6'h0C;
  localparam logic [OpcodeW-1:0] OP_ORI     = 6'h0D;
  localparam logic [OpcodeW-1:0] OP_XORI    = 6'h0E;
  localparam logic [OpcodeW-1:0] OP_LUI     = 6'h0F;
  localparam logic [OpcodeW-1:0] OP_LW      = 6'h23;
  localparam logic [OpcodeW-1:0] OP_SW      = 6'h2B;

  localparam logic [FunctW-1:0] FN_SLL  = 6'h00;
  localparam logic [FunctW-1:0] FN_SRL  = 6'h02;
  localparam logic [FunctW-1:0] FN_SRA  = 6'h03;
  localparam logic [FunctW-1:0] FN_JR   = 6'h08;
  localparam logic [FunctW-1:0] FN_ADDU = 6'h21;
  localparam logic [FunctW-1:0] FN_SUBU = 6'h23;
  localparam logic [FunctW-1:0] FN_AND  = 6'h24;
  localparam logic [FunctW-1:0] FN_OR   = 6'h25;
  localparam logic [FunctW-1:0] FN_XOR  = 6'h26;
  localparam logic [FunctW-1:0] FN_NOR  = 6'h27;
  localparam logic [FunctW-1:0] FN_SLT  = 6'h2A;
  localparam logic [FunctW-1:0] FN_SLTU = 6'h2B;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_READ  = 2'd1,
    MEM_WRITE = 2'd2
  } mem_access_e;

  typedef enum logic [1:0] {
    SRCB_RT     = 2'd0,
    SRCB_FOUR   = 2'd1,
    SRCB_IMM    = 2'd2,
    SRCB_BRANCH = 2'd3
  } alu_src_b_e;

  typedef enum logic [3:0] {
    ALU_ADD  = 4'd0,
    ALU_SUB  = 4'd1,
    ALU_AND  = 4'd2,
    ALU_OR   = 4'd3,
    ALU_XOR  = 4'd4,
    ALU_NOR  = 4'd5,
    ALU_SLL  = 4'd6,
    ALU_SRL  = 4'd7,
    ALU_SRA  = 4'd8,
    ALU_SLT  = 4'd9,
    ALU_LTU  = 4'd10,
    ALU_EQ   = 4'd11,
    ALU_NEQ  = 4'd12,
    ALU_LUI  = 4'd13
  } alu_op_e;

  typedef enum logic [1:0] {
    PCUPD_NONE = 2'd0,
    PCUPD_ALWAYS = 2'd1,
    PCUPD_COND = 2'd2
  } pc_update_e;

  typedef enum logic [1:0] {
    PCSRC_ALU    = 2'd0,
    PCSRC_ALUOUT = 2'd1,
    PCSRC_JUMP   = 2'd2,
    PCSRC_RS     = 2'd3
  } pc_source_e;

  typedef enum logic [1:0] {
    DEST_RT   = 2'd0,
    DEST_RD   = 2'd1,
    DEST_LINK = 2'd2
  } write_dest_e;

  typedef struct packed {
    logic [1:0] mem_access;
    logic       addr_from_alu;
    logic       alu_src_a;
    logic [1:0] alu_src_b;
    logic [3:0] alu_op;
    logic [1:0] pc_update;
    logic [1:0] pc_source;
    logic       ir_write;
    logic       reg_write;
    logic [1:0] write_dest;
    logic       mem_to_reg;
    logic       sign_extend;
  } ctrl_t;

  function automatic logic [3:0] rtype_alu(input logic [FunctW-1:0] funct);
    logic [3:0] op;
    case (funct)
      FN_SLL:  op = ALU_SLL;
      FN_SRL:  op = ALU_SRL;
      FN_SRA:  op = ALU_SRA;
      FN_ADDU: op = ALU_ADD;
      FN_SUBU: op = ALU_SUB;
      FN_AND:  op = ALU_AND;
      FN_OR:   op = ALU_OR;
      FN_XOR:  op = ALU_XOR;
      FN_NOR:  op = ALU_NOR;
      FN_SLT:  op = ALU_SLT;
      FN_SLTU: op = ALU_LTU;
      default: op = ALU_ADD;
    endcase
    return op;
  endfunction

endpackage

[rtl/core/mmcfsm_if.sv]
interface mmcfsm_req_if
  import mmcfsm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OpcodeW-1:0] opcode;
  logic [FunctW-1:0]  funct;

  modport source (output valid, output opcode, output funct, input ready);
  modport sink   (input valid, input opcode, input funct, output ready);
endinterface

interface mmcfsm_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] mem_access;
  logic       addr_from_alu;
  logic       alu_src_a;
  logic [1:0] alu_src_b;
  logic [3:0] alu_op;
  logic [1:0] pc_update;
  logic [1:0] pc_source;
  logic       ir_write;
  logic       reg_write;
  logic [1:0] write_dest;
  logic       mem_to_reg;
  logic       sign_extend;

  modport source (
    output valid, output mem_access, output addr_from_alu, output alu_src_a,
    output alu_src_b, output alu_op, output pc_update, output pc_source,
    output ir_write, output reg_write, output write_dest, output mem_to_reg,
    output sign_extend, input ready
  );
  modport sink (
    input valid, input mem_access, input addr_from_alu, input alu_src_a,
    input alu_src_b, input alu_op, input pc_update, input pc_source,
    input ir_write, input reg_write, input write_dest, input mem_to_reg,
    input sign_extend, output ready
  );
endinterface

[rtl/core/multicycle_mips_control_fsm_unit.sv]
// Control unit for a multicycle MIPS-I subset datapath. Each request is one
// datapath clock step carrying the instruction's opcode and funct; the unit
// walks fetch, decode, execute, memory and writeback and returns the control
// word for the current step. One request is taken every cycle while the sink
// keeps up; each control word is registered in the output register, and a new
// request is taken while a word waits if the sink takes it in the same cycle.
// The step register advances as each request is taken and resets to fetch.
module multicycle_mips_control_fsm_unit
  import mmcfsm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  mmcfsm_req_if.sink   req_i,
  mmcfsm_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    StFetch  = 3'd0,
    StDecode = 3'd1,
    StExec   = 3'd2,
    StMem    = 3'd3,
    StWb     = 3'd4
  } step_e;

  step_e step_q, step_d;
  ctrl_t word_q, word_d;
  logic  valid_q;
  logic  accept;

  assign req_i.ready = !valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    word_d = '0;
    step_d = StFetch;
    case (step_q)
      StDecode: begin
        word_d.alu_src_b = SRCB_BRANCH;
        if (req_i.opcode == OP_J || req_i.opcode == OP_JAL) begin
          word_d.pc_update = PCUPD_ALWAYS;
          word_d.pc_source = PCSRC_JUMP;
          if (req_i.opcode == OP_JAL) begin
            word_d.reg_write  = 1'b1;
            word_d.write_dest = DEST_LINK;
          end
        end else begin
          step_d = StExec;
        end
      end
      StExec: begin
        step_d = StWb;
        case (req_i.opcode)
          OP_SPECIAL: begin
            if (req_i.funct == FN_JR) begin
              word_d.pc_update = PCUPD_ALWAYS;
              word_d.pc_source = PCSRC_RS;
              step_d = StFetch;
            end else begin
              word_d.write_dest = DEST_RD;
              word_d.alu_src_a  = 1'b1;
              word_d.alu_src_b  = SRCB_RT;
              word_d.alu_op     = rtype_alu(req_i.funct);
            end
          end
          OP_LW, OP_SW: begin
            word_d.alu_src_a   = 1'b1;
            word_d.alu_src_b   = SRCB_IMM;
            word_d.alu_op      = ALU_ADD;
            word_d.sign_extend = 1'b1;
            step_d = StMem;
          end
          OP_BEQ, OP_BNE: begin
            word_d.alu_src_a   = 1'b1;
            word_d.alu_src_b   = SRCB_RT;
            word_d.alu_op      = (req_i.opcode == OP_BEQ) ? ALU_EQ : ALU_NEQ;
            word_d.pc_update   = PCUPD_COND;
            word_d.pc_source   = PCSRC_ALUOUT;
            word_d.sign_extend = 1'b1;
            step_d = StFetch;
          end
          OP_LUI: begin
            word_d.alu_src_b = SRCB_IMM;
            word_d.alu_op    = ALU_LUI;
          end
          OP_ADD_IMM, OP_SLTI, OP_LTU_IMM, OP_ANDI, OP_ORI, OP_XORI: begin
            word_d.alu_src_a = 1'b1;
            word_d.alu_src_b = SRCB_IMM;
            case (req_i.opcode)
              OP_ADD_IMM: word_d.alu_op = ALU_ADD;
              OP_SLTI:    word_d.alu_op = ALU_SLT;
              OP_LTU_IMM: word_d.alu_op = ALU_LTU;
              OP_ANDI:    word_d.alu_op = ALU_AND;
              OP_ORI:     word_d.alu_op = ALU_OR;
              default:    word_d.alu_op = ALU_XOR;
            endcase
            word_d.sign_extend = (req_i.opcode == OP_ADD_IMM ||
                                  req_i.opcode == OP_SLTI ||
                                  req_i.opcode == OP_LTU_IMM);
          end
          default: step_d = StFetch;
        endcase
      end
      StMem: begin
        if (req_i.opcode == OP_LW) begin
          word_d.mem_access    = MEM_READ;
          word_d.addr_from_alu = 1'b1;
          step_d = StWb;
        end else if (req_i.opcode == OP_SW) begin
          word_d.mem_access    = MEM_WRITE;
          word_d.addr_from_alu = 1'b1;
        end
      end
      StWb: begin
        word_d.reg_write = 1'b1;
        if (req_i.opcode == OP_LW) begin
          word_d.mem_to_reg = 1'b1;
        end else if (req_i.opcode == OP_SPECIAL || req_i.opcode == OP_BEQ ||
                     req_i.opcode == OP_BNE) begin
          word_d.write_dest = DEST_RD;
        end
      end
      default: begin
        word_d.mem_access = MEM_READ;
        word_d.alu_src_b  = SRCB_FOUR;
        word_d.pc_update  = PCUPD_ALWAYS;
        word_d.ir_write   = 1'b1;
        step_d = StDecode;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= StFetch;
      valid_q <= 1'b0;
      word_q  <= '0;
    end else begin
      if (accept) begin
        step_q  <= step_d;
        word_q  <= word_d;
        valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid         = valid_q;
  assign rsp_o.mem_access    = word_q.mem_access;
  assign rsp_o.addr_from_alu = word_q.addr_from_alu;
  assign rsp_o.alu_src_a     = word_q.alu_src_a;
  assign rsp_o.alu_src_b     = word_q.alu_src_b;
  assign rsp_o.alu_op        = word_q.alu_op;
  assign rsp_o.pc_update     = word_q.pc_update;
  assign rsp_o.pc_source     = word_q.pc_source;
  assign rsp_o.ir_write      = word_q.ir_write;
  assign rsp_o.reg_write     = word_q.reg_write;
  assign rsp_o.write_dest    = word_q.write_dest;
  assign rsp_o.mem_to_reg    = word_q.mem_to_reg;
  assign rsp_o.sign_extend   = word_q.sign_extend;

endmodule
